>>> design/cppc_pkg.sv
// Shared types and constants for the convex polygon containment block.
package cppc_pkg;
  localparam int VERTEX_COUNT_DEF  = 1024;
  localparam int POLYGON_COUNT_DEF = 1024;
  localparam int MAX_CORNERS_DEF   = 8;
  localparam int COORD_BITS_DEF    = 24;

  localparam logic [1:0] MODE_VERTEX = 2'd0;
  localparam logic [1:0] MODE_CORNER = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam logic [1:0] ST_OUTSIDE = 2'd0;
  localparam logic [1:0] ST_INSIDE  = 2'd1;
  localparam logic [1:0] ST_EDGE    = 2'd2;
  localparam logic [1:0] ST_VERTEX  = 2'd3;

  localparam logic CFG_BOX_TOL  = 1'b0;
  localparam logic CFG_AREA_TOL = 1'b1;
endpackage

>>> design/cppc_ram.sv
// Generic single-port RAM with registered read.
module cppc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> design/cppc_mul.sv
// Shared signed multiplier with registered product.
module cppc_mul #(
  parameter int OP_BITS = 25
) (
  input  logic                        clk,
  input  logic signed [OP_BITS-1:0]   a,
  input  logic signed [OP_BITS-1:0]   b,
  output logic signed [2*OP_BITS-1:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

>>> design/convex_polygon_point_containment.sv
// Top level: convex polygon point containment with sequenced shared multiplier.
//
// Use:
//   Input requests are presented on mode/target_index/.../last_corner with
//   start; a request is taken at an edge with start high and busy low.
//   Mode 0 writes a vertex, mode 1 writes one polygon corner and grows the
//   polygon's bounding box, mode 2 queries a point against a polygon.
//   Only queries answer: one result on status/hit_index, marked by a
//   one-cycle done strobe. The receiver cannot stall; done is not held.
//   Register writes use cfg_valid/cfg_ready/cfg_index/cfg_data; index 0 is
//   box_tolerance, index 1 area_tolerance. cfg_ready is always high.
// Sequencing:
//   A vertex load writes in S_VLD; a corner load reads the vertex and box in
//   S_CRD and writes them in S_CUPD. A query walks its edges: every edge does
//   a corner read, a vertex read and two products through one multiplier
//   (S_CADR to S_CMP), and a walk that ends on an edge adds S_NADR. done
//   rises in the same cycle that busy falls; a new request may be taken in that cycle.
//   The single multiplier port and the one read port per store set this order.
// Reset:
//   rst clears the sequencer and the registers; stores are not cleared and
//   must be written before they are queried.
module convex_polygon_point_containment #(
  parameter int VERTEX_COUNT  = cppc_pkg::VERTEX_COUNT_DEF,
  parameter int POLYGON_COUNT = cppc_pkg::POLYGON_COUNT_DEF,
  parameter int MAX_CORNERS   = cppc_pkg::MAX_CORNERS_DEF,
  parameter int COORD_BITS    = cppc_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [9:0]         target_index,
  input  logic [2:0]         corner_slot,
  input  logic signed [23:0] x_coord,
  input  logic signed [23:0] y_coord,
  input  logic [9:0]         vertex_ref,
  input  logic signed [10:0] neighbour_ref,
  input  logic               last_corner,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [10:0] hit_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import cppc_pkg::*;

  localparam int VA  = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int PA  = (POLYGON_COUNT > 1) ? $clog2(POLYGON_COUNT) : 1;
  localparam int SA  = $clog2(MAX_CORNERS);
  localparam int CA  = PA + SA;
  localparam int NB  = $clog2(MAX_CORNERS + 1);
  localparam int DB  = COORD_BITS + 1;
  localparam int PB  = 2 * DB;
  localparam int XB  = PB + 1;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_VLD   = 14'b00000000000010,
    S_CRD   = 14'b00000000000100,
    S_CUPD  = 14'b00000000001000,
    S_QBOX  = 14'b00000000010000,
    S_QCHK  = 14'b00000000100000,
    S_CADR  = 14'b00000001000000,
    S_VADR  = 14'b00000010000000,
    S_VDAT  = 14'b00000100000000,
    S_MUL1  = 14'b00001000000000,
    S_MUL2  = 14'b00010000000000,
    S_CMP   = 14'b00100000000000,
    S_NADR  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t state;
  logic [15:0] box_tol;
  logic [31:0] area_tol;

  // latched request
  logic [9:0]         r_tgt;
  logic [2:0]         r_slot;
  logic signed [COORD_BITS-1:0] r_x, r_y;
  logic [9:0]         r_vref;
  logic [10:0]        r_nref;
  logic               r_last;

  // walk state
  logic [NB-1:0]      cnt, idx;
  logic               first;
  logic signed [DB-1:0] lx, ly, cx, cy;
  logic [VA-1:0]      cur_v;
  logic signed [PB-1:0] prod1;
  logic [1:0]         res_st;
  logic [10:0]        res_sp;

  // RAM ports
  logic               vx_we, cv_we, cc_we, bx_we;
  logic [VA-1:0]      v_addr;
  logic [CA-1:0]      c_addr;
  logic [PA-1:0]      p_addr;
  logic signed [COORD_BITS-1:0] vx_rd, vy_rd, bminx, bminy, bmaxx, bmaxy;
  logic signed [COORD_BITS-1:0] nminx, nminy, nmaxx, nmaxy;
  logic [VA-1:0]      cv_rd;
  logic [10:0]        cn_rd;
  logic [NB-1:0]      cc_rd;

  logic signed [DB-1:0] mul_a, mul_b;
  logic signed [PB-1:0] mul_p;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      box_tol  <= '0;
      area_tol <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BOX_TOL:  box_tol  <= cfg_data[15:0];
        CFG_AREA_TOL: area_tol <= cfg_data;
        default: ;
      endcase
    end
  end

  logic vtx_ok, poly_ok, slot_ok;
  assign vtx_ok  = ({22'd0, target_index} < 32'(VERTEX_COUNT));
  assign poly_ok = ({22'd0, r_tgt} < 32'(POLYGON_COUNT));
  assign slot_ok = ({29'd0, r_slot} < 32'(MAX_CORNERS)) &&
                   ({22'd0, r_vref} < 32'(VERTEX_COUNT));

  // address muxing
  always_comb begin
    v_addr = VA'(r_vref);
    if (state == S_IDLE) v_addr = VA'(target_index);
    else if (state == S_VLD) v_addr = VA'(r_tgt);
    else if (state == S_VADR) v_addr = cv_rd;
    p_addr = PA'(r_tgt);
    c_addr = {PA'(r_tgt), SA'(r_slot)};
    if (state == S_CADR || state == S_NADR || state == S_QCHK)
      c_addr = {PA'(r_tgt), idx[SA-1:0]};
    vx_we = (state == S_VLD);
    cv_we = (state == S_CUPD);
    cc_we = (state == S_CUPD) && r_last;
    bx_we = (state == S_CUPD);
  end

  always_comb begin
    if (r_slot == 3'd0) begin
      nminx = vx_rd; nmaxx = vx_rd; nminy = vy_rd; nmaxy = vy_rd;
    end else begin
      nminx = (vx_rd < bminx) ? vx_rd : bminx;
      nmaxx = (vx_rd > bmaxx) ? vx_rd : bmaxx;
      nminy = (vy_rd < bminy) ? vy_rd : bminy;
      nmaxy = (vy_rd > bmaxy) ? vy_rd : bmaxy;
    end
  end

  cppc_ram #(.WIDTH(COORD_BITS), .DEPTH(VERTEX_COUNT)) u_vx (
    .clk, .we(vx_we), .addr(v_addr), .wdata(r_x), .rdata(vx_rd));
  cppc_ram #(.WIDTH(COORD_BITS), .DEPTH(VERTEX_COUNT)) u_vy (
    .clk, .we(vx_we), .addr(v_addr), .wdata(r_y), .rdata(vy_rd));
  cppc_ram #(.WIDTH(VA), .DEPTH(1 << CA)) u_cv (
    .clk, .we(cv_we), .addr(c_addr), .wdata(VA'(r_vref)), .rdata(cv_rd));
  cppc_ram #(.WIDTH(11), .DEPTH(1 << CA)) u_cn (
    .clk, .we(cv_we), .addr(c_addr), .wdata(r_nref), .rdata(cn_rd));
  cppc_ram #(.WIDTH(NB), .DEPTH(1 << PA)) u_cc (
    .clk, .we(cc_we), .addr(p_addr), .wdata(NB'(r_slot) + NB'(1)), .rdata(cc_rd));
  cppc_ram #(.WIDTH(COORD_BITS), .DEPTH(1 << PA)) u_bnx (
    .clk, .we(bx_we), .addr(p_addr), .wdata(nminx), .rdata(bminx));
  cppc_ram #(.WIDTH(COORD_BITS), .DEPTH(1 << PA)) u_bny (
    .clk, .we(bx_we), .addr(p_addr), .wdata(nminy), .rdata(bminy));
  cppc_ram #(.WIDTH(COORD_BITS), .DEPTH(1 << PA)) u_bxx (
    .clk, .we(bx_we), .addr(p_addr), .wdata(nmaxx), .rdata(bmaxx));
  cppc_ram #(.WIDTH(COORD_BITS), .DEPTH(1 << PA)) u_bxy (
    .clk, .we(bx_we), .addr(p_addr), .wdata(nmaxy), .rdata(bmaxy));

  // one shared multiplier: lx*cy then ly*cx
  assign mul_a = (state == S_MUL1) ? lx : ly;
  assign mul_b = (state == S_MUL1) ? cy : cx;
  cppc_mul #(.OP_BITS(DB)) u_mul (.clk, .a(mul_a), .b(mul_b), .p(mul_p));

  // box test, widened by tolerance
  logic signed [COORD_BITS+1:0] tolx, pxw, pyw;
  logic box_out;
  assign tolx = (COORD_BITS+2)'({1'b0, box_tol});
  assign pxw  = (COORD_BITS+2)'(r_x);
  assign pyw  = (COORD_BITS+2)'(r_y);
  assign box_out = (pxw < (COORD_BITS+2)'(bminx) - tolx) ||
                   (pxw > (COORD_BITS+2)'(bmaxx) + tolx) ||
                   (pyw < (COORD_BITS+2)'(bminy) - tolx) ||
                   (pyw > (COORD_BITS+2)'(bmaxy) + tolx);

  // cross product compare
  logic signed [XB-1:0] xprod, mag;
  logic neg, colin, between;
  assign xprod   = XB'(prod1) - XB'(mul_p);
  assign neg     = xprod[XB-1];
  assign mag     = neg ? -xprod : xprod;
  assign colin   = (mag < XB'({1'b0, area_tol}));
  assign between = (cx != 0) ? ((cx > 0) != (lx > 0)) : ((cy > 0) != (ly > 0));

  logic signed [DB-1:0] dx, dy;
  assign dx = DB'(vx_rd) - DB'(r_x);
  assign dy = DB'(vy_rd) - DB'(r_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            r_tgt <= target_index; r_slot <= corner_slot;
            r_x <= COORD_BITS'(x_coord); r_y <= COORD_BITS'(y_coord);
            r_vref <= vertex_ref; r_nref <= neighbour_ref; r_last <= last_corner;
            case (mode)
              MODE_VERTEX: state <= vtx_ok ? S_VLD : S_IDLE;
              MODE_CORNER: state <= S_CRD;
              MODE_QUERY:  state <= S_QBOX;
              default:     state <= S_IDLE;
            endcase
          end
        end
        S_VLD: state <= S_IDLE;
        S_CRD: state <= (poly_ok && slot_ok) ? S_CUPD : S_IDLE;
        S_CUPD: state <= S_IDLE;
        S_QBOX: begin
          res_st <= ST_OUTSIDE; res_sp <= '0;
          state  <= S_QCHK;
          idx    <= '0;
        end
        S_QCHK: begin
          // box and count are readable now
          cnt <= cc_rd;
          if (!poly_ok || box_out || cc_rd == 0 || cc_rd > NB'(MAX_CORNERS)) begin
            state <= S_OUT;
          end else begin
            idx   <= cc_rd - NB'(1);
            first <= 1'b1;
            state <= S_CADR;
          end
        end
        S_CADR: state <= S_VADR;
        S_VADR: begin
          cur_v <= cv_rd;
          state <= S_VDAT;
        end
        S_VDAT: begin
          cx <= dx; cy <= dy;
          if (dx == 0 && dy == 0) begin
            res_st <= ST_VERTEX; res_sp <= 11'(cur_v);
            state  <= S_OUT;
          end else if (first) begin
            lx <= dx; ly <= dy; first <= 1'b0;
            idx <= '0;
            state <= S_CADR;
          end else begin
            state <= S_MUL1;
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: begin
          prod1 <= mul_p;
          state <= S_CMP;
        end
        S_CMP: begin
          if (colin) begin
            if (between) begin
              res_st <= ST_EDGE;
              idx    <= (idx == 0) ? cnt - NB'(1) : idx - NB'(1);
              state  <= S_NADR;
            end else begin
              state <= S_OUT;
            end
          end else if (neg) begin
            state <= S_OUT;
          end else if (idx == cnt - NB'(1)) begin
            res_st <= ST_INSIDE;
            state  <= S_OUT;
          end else begin
            lx <= cx; ly <= cy;
            idx <= idx + NB'(1);
            state <= S_CADR;
          end
        end
        S_NADR: state <= S_OUT;
        S_OUT: begin
          if (res_st == ST_EDGE) res_sp <= cn_rd;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // S_NADR drives the neighbour address; S_OUT captures it for the result
  assign status    = res_st;
  assign hit_index = res_sp;
endmodule

>>> design/cppc_checker.sv
// Port-level checks for the containment block, bound to the top level.
module cppc_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] mode,
  input logic       done,
  input logic       cfg_ready
);
  import cppc_pkg::*;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held two cycles");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_QUERY)) |=> busy) else $error("request not taken");
  a_no_result_load: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_VERTEX)) |=> ##1 !done)
    else $error("result after vertex load");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready) else $error("config port not ready");
endmodule

bind convex_polygon_point_containment cppc_checker u_cppc_checker (
  .clk, .rst, .start, .busy, .mode, .done, .cfg_ready);

>>> dv/tb_convex_polygon_point_containment.sv
// Testbench for the convex polygon point containment block.
`timescale 1ns / 100ps

module tb_convex_polygon_point_containment;
  import cppc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 80;  // longer than an 8-corner query
  localparam int RAND_ITEMS  = 750;

  // Scoreboard: keeps a shadow of the block's tables and registers, predicts
  // each query answer and compares it with what the block reports.
  class containment_scoreboard;
    int              vert_x[1024];
    int              vert_y[1024];
    int              corner_vert[8192];
    logic     [10:0] corner_nbr[8192];
    int              corner_cnt[1024];
    int              bmin_x[1024], bmin_y[1024], bmax_x[1024], bmax_y[1024];
    longint          box_tol;
    longint          area_tol;
    logic     [12:0] answers_q[$];  // {status, hit_index}
    int              errors;

    function new();
      box_tol  = 0;
      area_tol = 0;
      errors   = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] data);
      if (idx == CFG_BOX_TOL) box_tol = longint'(data[15:0]);
      else area_tol = longint'({32'd0, data});
    endfunction

    // Edge walk with exact cross products; products fit easily in 64 bits.
    function logic [12:0] locate_point(int poly, longint px, longint py);
      int     n, base, v;
      longint lx, ly, cx, cy, xprod, mag;
      bit     between;
      if (px < bmin_x[poly] - box_tol || px > bmax_x[poly] + box_tol ||
          py < bmin_y[poly] - box_tol || py > bmax_y[poly] + box_tol)
        return {ST_OUTSIDE, 11'd0};
      n = corner_cnt[poly];
      if (n == 0) return {ST_OUTSIDE, 11'd0};
      base = poly * 8;
      v  = corner_vert[base + n - 1];
      lx = vert_x[v] - px;
      ly = vert_y[v] - py;
      if (lx == 0 && ly == 0) return {ST_VERTEX, 11'(v)};
      for (int i = 0; i < n; i++) begin
        v  = corner_vert[base + i];
        cx = vert_x[v] - px;
        cy = vert_y[v] - py;
        if (cx == 0 && cy == 0) return {ST_VERTEX, 11'(v)};
        xprod = lx * cy - ly * cx;
        mag   = xprod < 0 ? -xprod : xprod;
        if (mag < area_tol) begin
          between = cx != 0 ? ((cx > 0) != (lx > 0)) : ((cy > 0) != (ly > 0));
          if (!between) return {ST_OUTSIDE, 11'd0};
          return {ST_EDGE, corner_nbr[base + (i == 0 ? n - 1 : i - 1)]};
        end
        if (xprod < 0) return {ST_OUTSIDE, 11'd0};
        lx = cx;
        ly = cy;
      end
      return {ST_INSIDE, 11'd0};
    endfunction

    function void note_request(logic [1:0] md, logic [9:0] tgt, logic [2:0] sl,
                               logic signed [23:0] x, logic signed [23:0] y,
                               logic [9:0] vr, logic signed [10:0] nr, logic lc);
      int k, vx, vy;
      case (md)
        MODE_VERTEX: begin
          vert_x[tgt] = x;
          vert_y[tgt] = y;
        end
        MODE_CORNER: begin
          k = tgt * 8 + sl;
          corner_vert[k] = vr;
          corner_nbr[k]  = nr;
          vx = vert_x[vr];
          vy = vert_y[vr];
          if (sl == 0) begin
            bmin_x[tgt] = vx; bmax_x[tgt] = vx;
            bmin_y[tgt] = vy; bmax_y[tgt] = vy;
          end else begin
            if (vx < bmin_x[tgt]) bmin_x[tgt] = vx;
            if (vx > bmax_x[tgt]) bmax_x[tgt] = vx;
            if (vy < bmin_y[tgt]) bmin_y[tgt] = vy;
            if (vy > bmax_y[tgt]) bmax_y[tgt] = vy;
          end
          if (lc) corner_cnt[tgt] = sl + 1;
        end
        MODE_QUERY: answers_q.insert(answers_q.size(), locate_point(tgt, x, y));
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("mismatch @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic signed [10:0] sp);
      logic [12:0] exp_ans;
      if (answers_q.size() == 0) begin
        report($sformatf("unexpected result status=%0d index=%0d", st, sp));
        return;
      end
      exp_ans = answers_q.pop_front();
      if (st !== exp_ans[12:11])
        report($sformatf("status %0d, expected %0d", st, exp_ans[12:11]));
      if (sp !== exp_ans[10:0])
        report($sformatf("hit_index %0d, expected %0d", sp,
                         $signed(exp_ans[10:0])));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         mode = MODE_VERTEX;
  logic [9:0]         target_index = '0;
  logic [2:0]         corner_slot = '0;
  logic signed [23:0] x_coord = '0;
  logic signed [23:0] y_coord = '0;
  logic [9:0]         vertex_ref = '0;
  logic signed [10:0] neighbour_ref = '0;
  logic               last_corner = 1'b0;
  logic               done;
  logic [1:0]         status;
  logic signed [10:0] hit_index;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_BOX_TOL;
  logic [31:0]        cfg_data = '0;

  convex_polygon_point_containment dut (.*);

  always #4 clk = ~clk;

  containment_scoreboard sb = new();

  // Shadow of which entries hold written data, so queries never read
  // uninitialized table entries.
  bit       vert_ok[1024];
  bit [7:0] slots_set[1024];
  int       poly_cnt[1024];
  bit       idle_on = 1'b1;
  int       issued = 0;
  int       cycles = 0;

  // Global watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL convex_polygon_point_containment");
      $finish;
    end
  end

  // Results: one-cycle done strobe, cannot be stalled.
  always @(posedge clk)
    if (!rst && done) sb.check_result(status, hit_index);

  function automatic bit poly_ready(int p);
    if (poly_cnt[p] == 0) return 1'b0;
    for (int s = 0; s < poly_cnt[p]; s++)
      if (!slots_set[p][s]) return 1'b0;
    return 1'b1;
  endfunction

  // Drive one request at the falling edge, hold until taken (start && !busy).
  // Unused fields carry random values to exercise every input bit.
  task automatic send(logic [1:0] md, int tgt, int sl, int x, int y,
                      int vr, int nr, bit lc);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    mode          = md;
    target_index  = 10'(tgt);
    corner_slot   = 3'(sl);
    x_coord       = 24'(x);
    y_coord       = 24'(y);
    vertex_ref    = 10'(vr);
    neighbour_ref = 11'(nr);
    last_corner   = lc;
    start         = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(mode, target_index, corner_slot, x_coord, y_coord,
                    vertex_ref, neighbour_ref, last_corner);
    if (md != 2'd3) issued++;
    @(negedge clk);
  endtask

  task automatic load_vertex(int idx, int x, int y);
    send(MODE_VERTEX, idx, $urandom_range(0, 7), x, y, $urandom_range(0, 1023),
         $urandom_range(0, 2047), $urandom_range(0, 1));
    vert_ok[idx] = 1'b1;
  endtask

  task automatic load_corner(int p, int sl, int vr, int nr, bit lc);
    send(MODE_CORNER, p, sl, $urandom, $urandom, vr, nr, lc);
    slots_set[p][sl] = 1'b1;
    if (lc) poly_cnt[p] = sl + 1;
  endtask

  task automatic query(int p, int x, int y);
    send(MODE_QUERY, p, $urandom_range(0, 7), x, y, $urandom_range(0, 1023),
         $urandom_range(0, 2047), $urandom_range(0, 1));
  endtask

  // Drain: all answers in, then let any trailing load finish.
  task automatic drain();
    start = 1'b0;
    while (sb.answers_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic int rand_nbr();
    return $urandom_range(0, 4) == 0 ? -1 : int'($urandom_range(0, 1023));
  endfunction

  // Octagon directions; any in-order subset is a convex CCW polygon.
  // Even radius keeps every coordinate even so edge midpoints are exact.
  task automatic build_and_probe();
    int p, base, cx, cy, r, a, n, k, nq, kind, e;
    int dx[8], dy[8], sel[8], px[8], py[8];
    bit keep[8];
    p    = $urandom_range(0, 1023);
    base = $urandom_range(0, 1016);
    // most shapes small so tolerances matter, a few large
    r    = ($urandom_range(0, 9) == 0) ? $urandom_range(1000, 50000) * 2
                                       : $urandom_range(2, 40) * 2;
    a    = ((r * 7) / 10) & ~1;
    cx   = ($urandom_range(0, 8000000) - 4000000) & ~1;
    cy   = ($urandom_range(0, 8000000) - 4000000) & ~1;
    dx = '{r, a, 0, -a, -r, -a, 0, a};
    dy = '{0, a, r, a, 0, -a, -r, -a};
    n = $urandom_range(3, 8);
    keep = '{default: 1'b1};
    for (int d = 8; d > n; d--) begin
      k = $urandom_range(0, 7);
      while (!keep[k]) k = (k + 1) % 8;
      keep[k] = 1'b0;
    end
    k = 0;
    for (int d = 0; d < 8; d++)
      if (keep[d]) begin
        sel[k] = base + d;
        px[k]  = cx + dx[d];
        py[k]  = cy + dy[d];
        load_vertex(sel[k], px[k], py[k]);
        k++;
      end
    for (int s = 0; s < n; s++)
      load_corner(p, s, sel[s], rand_nbr(), s == n - 1);
    nq = $urandom_range(4, 9);
    repeat (nq) begin
      kind = $urandom_range(0, 5);
      e    = $urandom_range(0, n - 1);
      case (kind)
        0: query(p, px[e], py[e]);
        1: query(p, (px[e] + px[(e + 1) % n]) / 2, (py[e] + py[(e + 1) % n]) / 2);
        2, 3: query(p, cx + $urandom_range(0, 2 * r + 40) - r - 20,
                    cy + $urandom_range(0, 2 * r + 40) - r - 20);
        4: query(p, cx, cy);
        default: query(p, $urandom, $urandom);
      endcase
    end
  endtask

  task automatic random_phase(int items);
    int stop_at, p, v, tries;
    stop_at = issued + items;
    while (issued < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: build_and_probe();
        6: load_vertex($urandom_range(0, 1023), $urandom, $urandom);
        7: begin
          // stray corner write, possibly breaking a polygon's corner set
          v = $urandom_range(0, 1023);
          tries = 0;
          while (!vert_ok[v] && tries < 30) begin
            v = $urandom_range(0, 1023);
            tries++;
          end
          if (vert_ok[v])
            load_corner($urandom_range(0, 1023), $urandom_range(0, 7), v,
                        rand_nbr(), $urandom_range(0, 1));
        end
        8: send(2'd3, $urandom_range(0, 1023), $urandom_range(0, 7), $urandom,
                $urandom, $urandom_range(0, 1023), $urandom_range(0, 2047),
                $urandom_range(0, 1));
        default: begin
          p = $urandom_range(0, 1023);
          tries = 0;
          while (!poly_ready(p) && tries < 30) begin
            p = $urandom_range(0, 1023);
            tries++;
          end
          if (poly_ready(p)) query(p, $urandom, $urandom);
        end
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(CFG_BOX_TOL, 32'd0);
    write_reg(CFG_AREA_TOL, 32'd0);

    // Directed: unit square (256 = 1.0) in polygon 0.
    load_vertex(0, 0, 0);
    load_vertex(1, 256, 0);
    load_vertex(2, 256, 256);
    load_vertex(3, 0, 256);
    load_corner(0, 0, 0, 5, 1'b0);
    load_corner(0, 1, 1, -1, 1'b0);
    load_corner(0, 2, 2, 1023, 1'b0);
    load_corner(0, 3, 3, 7, 1'b1);
    query(0, 128, 128);   // inside
    query(0, 128, 0);     // on bottom edge
    query(0, 256, 128);   // on border edge
    query(0, 0, 0);       // on first corner
    query(0, 0, 256);     // on last corner, caught before the walk
    query(0, 300, 300);   // box reject
    query(0, -8388608, 8388607);
    // Extreme coordinates, top indexes, in polygon 1023.
    load_vertex(1023, -8388608, -8388608);
    load_vertex(1022, 8388607, -8388608);
    load_vertex(1021, 0, 8388607);
    load_corner(1023, 0, 1023, 1023, 1'b0);
    load_corner(1023, 1, 1022, -1, 1'b0);
    load_corner(1023, 2, 1021, 0, 1'b1);
    query(1023, 0, 0);
    query(1023, 8388607, -8388608);
    query(1023, -8388608, 8388607);
    send(2'd3, 0, 0, 0, 0, 0, 0, 1'b0);  // unused mode, no answer

    random_phase(RAND_ITEMS / 5);

    // Pause until every answer is in, then carry on without reconfiguring.
    drain();
    random_phase(RAND_ITEMS / 10);

    drain();
    write_reg(CFG_BOX_TOL, 32'd65535);
    write_reg(CFG_AREA_TOL, 32'hFFFF_FFFF);
    random_phase(RAND_ITEMS / 5);

    drain();
    write_reg(CFG_BOX_TOL, $urandom_range(1, 512));
    write_reg(CFG_AREA_TOL, $urandom_range(1, 65536));
    random_phase(RAND_ITEMS / 4);

    // Final stretch back-to-back with area tolerance off and a small box tolerance.
    drain();
    write_reg(CFG_BOX_TOL, $urandom_range(0, 64));
    write_reg(CFG_AREA_TOL, 32'd0);
    idle_on = 1'b0;
    random_phase(RAND_ITEMS / 4);

    drain();
    if (sb.errors == 0 && sb.answers_q.size() == 0) begin
      $display("PASS convex_polygon_point_containment");
    end else begin
      $display("FAIL convex_polygon_point_containment");
    end
    $finish;
  end
endmodule
